@@ src/fth_pkg.sv @@
// ----------------------------------------------------------------------------
// fth_pkg: shared types and constants of the float to hex text converter
// Holds the controller states, the character selector, the command and
// status bundles between controller and datapath, and the digit encoder.
// ----------------------------------------------------------------------------
package fth_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SKIP,
    ST_INT,
    ST_DOT,
    ST_ZERO,
    ST_FRAC
  } fth_state_e;

  typedef enum logic [1:0] {
    CH_DIGIT,
    CH_DOT,
    CH_ZERO,
    CH_NONE
  } fth_char_e;

  localparam logic [1:0] STAT_OK  = 2'd0;
  localparam logic [1:0] STAT_OVF = 2'd1;
  localparam logic [1:0] STAT_INV = 2'd2;

  localparam logic [7:0] EXP_ALL_ONES = 8'hFF;
  localparam logic [7:0] EXP_OVF      = 8'd158;
  localparam logic signed [8:0] EXP_BIAS_OFS = 9'sd150;
  localparam logic signed [8:0] SUBN_SCALE   = -9'sd149;
  localparam logic signed [6:0] NIB_TOP      = 7'sd7;

  localparam logic [6:0] CHAR_DOT   = 7'h2E;
  localparam logic [6:0] CHAR_ZERO  = 7'h30;
  localparam logic [6:0] CHAR_ALPHA = 7'h41;

  typedef struct packed {
    logic      load;
    logic      dec;
    logic      emit;
    fth_char_e kind;
    logic      last;
  } fth_cmd_t;

  typedef struct packed {
    logic digit_nz;
    logic nib_zero;
    logic tail_zero;
    logic err;
  } fth_stat_t;

  function automatic logic [6:0] hex_char(input logic [3:0] d);
    logic [6:0] c;
    if (d < 4'd10) begin
      c = CHAR_ZERO + {3'b000, d};
    end else begin
      c = CHAR_ALPHA + {3'b000, d} - 7'd10;
    end
    return c;
  endfunction

endpackage

@@ src/fth_ctrl.sv @@
// ----------------------------------------------------------------------------
// fth_ctrl: sequencer of the float to hex text converter
// Walks the nibble positions from the top of the integer part down through
// the fraction and tells the datapath which character to emit.
// ----------------------------------------------------------------------------
module fth_ctrl import fth_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  fth_stat_t stat_i,
  output fth_cmd_t  cmd_o
);

  fth_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start) state_d = ST_SKIP;
      end
      ST_SKIP: begin
        if (stat_i.err) begin
          state_d = ST_IDLE;
        end else if (stat_i.digit_nz) begin
          state_d = ST_INT;
        end else if (stat_i.nib_zero) begin
          state_d = ST_DOT;
        end
      end
      ST_INT: begin
        if (stat_i.nib_zero) state_d = ST_DOT;
      end
      ST_DOT: begin
        // The position now points at the first fraction nibble.
        if (!stat_i.digit_nz && stat_i.tail_zero) begin
          state_d = ST_ZERO;
        end else begin
          state_d = ST_FRAC;
        end
      end
      ST_ZERO: state_d = ST_IDLE;
      ST_FRAC: begin
        if (stat_i.tail_zero) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '{load: 1'b0, dec: 1'b0, emit: 1'b0, kind: CH_DIGIT, last: 1'b0};
    busy       = 1'b1;
    case (state_q)
      ST_IDLE: begin
        busy       = 1'b0;
        cmd_o.load = start;
      end
      ST_SKIP: begin
        if (stat_i.err) begin
          cmd_o.emit = 1'b1;
          cmd_o.kind = CH_NONE;
          cmd_o.last = 1'b1;
        end else if (!stat_i.digit_nz) begin
          cmd_o.dec = 1'b1;
        end
      end
      ST_INT: begin
        cmd_o.emit = 1'b1;
        cmd_o.dec  = 1'b1;
      end
      ST_DOT: begin
        cmd_o.emit = 1'b1;
        cmd_o.kind = CH_DOT;
      end
      ST_ZERO: begin
        cmd_o.emit = 1'b1;
        cmd_o.kind = CH_ZERO;
        cmd_o.last = 1'b1;
      end
      ST_FRAC: begin
        cmd_o.emit = 1'b1;
        cmd_o.dec  = 1'b1;
        cmd_o.last = stat_i.tail_zero;
      end
      default: busy = 1'b0;
    endcase
  end

endmodule

@@ src/fth_datapath.sv @@
// ----------------------------------------------------------------------------
// fth_datapath: operand registers and digit extraction
// Holds the significand, the binary scale and the current nibble position,
// picks the four bits of that nibble and registers each output character.
// ----------------------------------------------------------------------------
module fth_datapath import fth_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [31:0] float_bits_i,
  input  fth_cmd_t    cmd_i,
  output fth_stat_t   stat_o,
  output logic        strobe_o,
  output logic [6:0]  ascii_char_o,
  output logic        last_char_o,
  output logic [1:0]  status_o
);

  logic [23:0]        sig_q;
  logic signed [8:0]  scale_q;
  logic signed [6:0]  nib_q;
  logic [1:0]         err_q;
  logic               strobe_q;
  logic [6:0]         char_q;
  logic               last_q;
  logic [1:0]         stat_q;

  logic [7:0]         expf;
  logic signed [9:0]  idx;
  logic signed [9:0]  pos;
  logic [29:0]        ext;
  logic [29:0]        shifted;
  logic [3:0]         digit;
  logic               tail_zero;
  logic [6:0]         char_d;

  assign expf = float_bits_i[30:23];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      if (expf == '0) begin
        sig_q   <= {1'b0, float_bits_i[22:0]};
        scale_q <= SUBN_SCALE;
      end else begin
        sig_q   <= {1'b1, float_bits_i[22:0]};
        scale_q <= $signed({1'b0, expf}) - EXP_BIAS_OFS;
      end
      if (expf == EXP_ALL_ONES) begin
        err_q <= STAT_INV;
      end else if (expf >= EXP_OVF) begin
        err_q <= STAT_OVF;
      end else begin
        err_q <= STAT_OK;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      nib_q <= NIB_TOP;
    end else if (cmd_i.dec) begin
      nib_q <= nib_q - 7'sd1;
    end
  end

  // Bit index into the significand of the lowest bit of the current nibble.
  assign idx = $signed({nib_q[6], nib_q, 2'b00}) - $signed({scale_q[8], scale_q});
  assign pos = idx + 10'sd3;
  assign ext = {3'b000, sig_q, 3'b000};
  assign shifted = ext >> pos[4:0];

  always_comb begin
    if (idx >= -10'sd3 && idx <= 10'sd23) begin
      digit = shifted[3:0];
    end else begin
      digit = 4'd0;
    end
  end

  // True when no set bit lies below the current nibble.
  always_comb begin
    if (idx <= 10'sd0) begin
      tail_zero = 1'b1;
    end else if (idx >= 10'sd24) begin
      tail_zero = (sig_q == '0);
    end else begin
      tail_zero = ((sig_q & ~({24{1'b1}} << idx[4:0])) == '0);
    end
  end

  assign stat_o = '{digit_nz:  (digit != 4'd0),
                    nib_zero:  (nib_q == 7'sd0),
                    tail_zero: tail_zero,
                    err:       (err_q != STAT_OK)};

  always_comb begin
    case (cmd_i.kind)
      CH_DIGIT: char_d = hex_char(digit);
      CH_DOT:   char_d = CHAR_DOT;
      CH_ZERO:  char_d = CHAR_ZERO;
      default:  char_d = 7'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      char_q <= char_d;
      last_q <= cmd_i.last;
      stat_q <= (cmd_i.kind == CH_NONE) ? err_q : STAT_OK;
    end
  end

  assign strobe_o     = strobe_q;
  assign ascii_char_o = char_q;
  assign last_char_o  = last_q;
  assign status_o     = stat_q;

endmodule

@@ src/float_to_hex_text.sv @@
// ----------------------------------------------------------------------------
// float_to_hex_text: single precision magnitude to ASCII hexadecimal text
//
//   channel   signals                                   direction  control
//   request   float_bits_i                              in         start / busy
//   result    ascii_char_o, last_char_o, status_o       out        strobe_o
//
// A request is taken when start is high and busy is low. After the accepting
// edge the sequencer skips leading zero integer nibbles, sends each integer
// digit from the first nonzero one down (found in the skip state, sent from
// the integer state), the point, and each fraction digit up to the last
// nonzero one or a lone zero; an error request gives one character with its
// status. No new request is taken until the current one has issued its last
// character. Each character is on the outputs for one cycle with strobe_o;
// the receiver cannot stall. Reset clears the sequencer and the strobe.
// ----------------------------------------------------------------------------
module float_to_hex_text import fth_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] float_bits_i,
  output logic        strobe_o,
  output logic [6:0]  ascii_char_o,
  output logic        last_char_o,
  output logic [1:0]  status_o
);

  fth_cmd_t  cmd;
  fth_stat_t stat;

  fth_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  fth_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .float_bits_i (float_bits_i),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .strobe_o     (strobe_o),
    .ascii_char_o (ascii_char_o),
    .last_char_o  (last_char_o),
    .status_o     (status_o)
  );

endmodule

@@ verif/float_to_hex_text_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// float_to_hex_text_tb: self-checking bench for the float to hex text block
// Issues directed and random single precision patterns through the start /
// busy handshake. A scoreboard turns each request into the characters it
// must produce and compares every strobed character field by field.
// ----------------------------------------------------------------------------
module float_to_hex_text_tb import fth_pkg::*; ();

  localparam int CLK_PERIOD  = 10;
  localparam int IDLE_LIMIT  = 2000;
  localparam int DRAIN_WAIT  = 60;
  localparam int RAND_ITEMS  = 406;
  localparam int SHOW_ERRORS = 10;

  typedef struct packed {
    logic [6:0] ch;
    logic       last;
    logic [1:0] st;
  } text_char_t;

  class hex_text_board;
    text_char_t expected_chars[$];
    int         mismatches = 0;
    int         chars_checked = 0;
    int         ovf_seen = 0;
    int         inv_seen = 0;

    function logic [6:0] nibble_to_ascii(logic [3:0] d);
      if (d < 4'd10) begin
        return CHAR_ZERO + 7'(d);
      end
      return CHAR_ALPHA + 7'(d - 4'd10);
    endfunction

    function void push_char(logic [6:0] ch, logic last, logic [1:0] st);
      text_char_t c;
      c.ch = ch;
      c.last = last;
      c.st = st;
      expected_chars.insert(expected_chars.size(), c);
    endfunction

    // Works out the full text of one accepted request.
    function void note_request(logic [31:0] bits);
      logic [7:0]  expf;
      logic [23:0] sig;
      logic [63:0] ipart;
      logic [3:0]  d;
      int          scale;
      int          msb;
      int          lsb;
      int          n_int;
      int          n_frac;
      int          idx;
      expf = bits[30:23];
      msb = -1;
      lsb = -1;
      ipart = '0;
      if (expf == 8'd0) begin
        sig = {1'b0, bits[22:0]};
        scale = -149;
      end else begin
        sig = {1'b1, bits[22:0]};
        scale = int'(expf) - 150;
      end
      if (expf == EXP_ALL_ONES) begin
        push_char(7'd0, 1'b1, STAT_INV);
        return;
      end
      for (int i = 0; i < 24; i++) begin
        if (sig[i]) begin
          if (lsb < 0) lsb = i;
          msb = i;
        end
      end
      if (msb >= 0 && scale + msb >= 31) begin
        push_char(7'd0, 1'b1, STAT_OVF);
        return;
      end
      if (msb >= 0) begin
        if (scale >= 0) begin
          ipart = 64'(sig) << scale;
        end else if (-scale < 24) begin
          ipart = 64'(sig >> (-scale));
        end
      end
      n_int = 0;
      while (n_int < 8 && (ipart >> (4 * n_int)) != 64'd0) n_int++;
      n_frac = (lsb >= 0 && scale + lsb < 0) ? (3 - (scale + lsb)) / 4 : 0;
      for (int i = n_int - 1; i >= 0; i--) begin
        push_char(nibble_to_ascii(ipart[4*i +: 4]), 1'b0, STAT_OK);
      end
      push_char(CHAR_DOT, 1'b0, STAT_OK);
      if (n_frac == 0) begin
        push_char(CHAR_ZERO, 1'b1, STAT_OK);
      end else begin
        for (int i = 1; i <= n_frac; i++) begin
          // Fraction digit i holds the bits of weight 2^-4i up to 2^-4i+3.
          for (int j = 0; j < 4; j++) begin
            idx = -4 * i + j - scale;
            d[j] = (idx >= 0 && idx <= 23) ? sig[idx] : 1'b0;
          end
          push_char(nibble_to_ascii(d), i == n_frac, STAT_OK);
        end
      end
    endfunction

    function void check_char(logic [6:0] ch, logic last, logic [1:0] st);
      text_char_t want;
      chars_checked++;
      if (st == STAT_OVF) ovf_seen++;
      if (st == STAT_INV) inv_seen++;
      if (expected_chars.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOW_ERRORS)
          $display("%0t: unexpected character %h last %b status %0d", $realtime, ch, last, st);
        return;
      end
      want = expected_chars.pop_front();
      if (want.ch !== ch || want.last !== last || want.st !== st) begin
        mismatches++;
        if (mismatches <= SHOW_ERRORS)
          $display("%0t: mismatch: expected char %h last %b status %0d, got %h %b %0d",
                   $realtime, want.ch, want.last, want.st, ch, last, st);
      end
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction

    function void flag_leftovers();
      if (expected_chars.size() != 0) begin
        mismatches += expected_chars.size();
        $display("%0d expected characters never arrived", expected_chars.size());
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic [31:0] float_bits_i = '0;
  logic        busy;
  logic        strobe_o;
  logic [6:0]  ascii_char_o;
  logic        last_char_o;
  logic [1:0]  status_o;

  hex_text_board board = new;
  int            requests_sent = 0;
  int            quiet_cycles = 0;

  float_to_hex_text dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .float_bits_i (float_bits_i),
    .strobe_o     (strobe_o),
    .ascii_char_o (ascii_char_o),
    .last_char_o  (last_char_o),
    .status_o     (status_o)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && strobe_o) begin
      board.check_char(ascii_char_o, last_char_o, status_o);
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || strobe_o) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < IDLE_LIMIT) @(posedge clk_i);
    $display("Timeout: no request or character for %0d cycles", IDLE_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  // Called at a rising edge. Start stays high across back-to-back requests.
  task automatic issue_request(input logic [31:0] bits, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    float_bits_i <= bits;
    do @(posedge clk_i); while (busy);
    board.note_request(bits);
    requests_sent++;
  endtask

  task automatic drain_text();
    start <= 1'b0;
    do @(posedge clk_i); while (board.pending() != 0);
  endtask

  function automatic logic [31:0] random_float();
    logic [31:0] bits;
    int          sel;
    bits = $urandom;
    sel = $urandom_range(0, 99);
    if (sel < 45) begin
      // Ordinary magnitudes below the overflow bound, with or without integer digits.
      bits[30:23] = 8'($urandom_range(103, 157));
      if ($urandom_range(0, 1)) bits[22:0] = bits[22:0] & (23'h7FFFFF << $urandom_range(0, 22));
    end else if (sel < 60) begin
      bits[30:23] = 8'($urandom_range(120, 160));
      bits[22:0] = bits[22:0] & 23'($urandom) & 23'($urandom);
    end else if (sel < 70) begin
      bits[30:23] = 8'd0;
      bits[22:0] = bits[22:0] >> $urandom_range(0, 22);
    end else if (sel < 78) begin
      bits[30:23] = EXP_ALL_ONES;
      if ($urandom_range(0, 3) == 0) bits[22:0] = '0;
    end else if (sel < 85) begin
      bits[30:23] = 8'($urandom_range(158, 254));
    end
    return bits;
  endfunction

  logic [31:0] directed_values[] = '{
    32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'h3F00_0000, 32'h3FC0_0000,
    32'h4120_0000, 32'h457F_F000, 32'hC2F6_E979, 32'h3DCC_CCCD, 32'h3F7F_FFFF,
    32'h0000_0001, 32'h807F_FFFF, 32'h0080_0000, 32'h4B7F_FFFF, 32'h4B80_0000,
    32'h4EFF_FFFF, 32'h4F00_0000, 32'hCF00_0000, 32'h7F7F_FFFF, 32'h7F80_0000,
    32'hFF80_0000, 32'h7FC0_0000, 32'h7F80_0001, 32'hFFFF_FFFF
  };

  initial begin
    int gap;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_values[i]) begin
      issue_request(directed_values[i], $urandom_range(0, 11));
    end
    // Let the block run dry once before the random part.
    drain_text();

    for (int k = 0; k < RAND_ITEMS; k++) begin
      gap = ((k / 40) % 3 == 1) ? 0 : $urandom_range(0, 11);
      issue_request(random_float(), gap);
      if (k == RAND_ITEMS / 2) drain_text();
    end
    start <= 1'b0;

    while (board.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    board.flag_leftovers();

    $display("Sent %0d requests (%0d directed) and checked %0d characters.",
             requests_sent, directed_values.size(), board.chars_checked);
    $display("Error results seen: %0d overflow, %0d infinity or NaN; %0d mismatches.",
             board.ovf_seen, board.inv_seen, board.mismatches);
    if (board.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ float_to_hex_text.f @@
src/fth_pkg.sv
src/fth_ctrl.sv
src/fth_datapath.sv
src/float_to_hex_text.sv
verif/float_to_hex_text_tb.sv
